// ----- rtl/usm_pkg.sv -----
`default_nettype none

package usm_pkg;

    // Reset values of the configuration registers.
    localparam logic [15:0] RADIUS_RST   = 16'd256;
    localparam logic [7:0]  RINGS_RST    = 8'd9;
    localparam logic [7:0]  SECTIONS_RST = 8'd9;

    // Configuration register indexes.
    localparam logic [1:0] CFG_RADIUS   = 2'd0;
    localparam logic [1:0] CFG_RINGS    = 2'd1;
    localparam logic [1:0] CFG_SECTIONS = 2'd2;

    // Default parameter values.
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int INDEX_BITS_DEF    = 16;

    // CORDIC start vector length, 0.60725293 in Q2.30.
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    // Arctangent of 2^-k as a fraction of a turn, scaled by 2^32.
    function automatic logic [31:0] atan_turn(input int k);
        logic [31:0] v;
        case (k)
            0:       v = 32'd536870912;
            1:       v = 32'd316933406;
            2:       v = 32'd167458907;
            3:       v = 32'd85004756;
            4:       v = 32'd42667331;
            5:       v = 32'd21354465;
            6:       v = 32'd10679838;
            7:       v = 32'd5340245;
            8:       v = 32'd2670163;
            9:       v = 32'd1335087;
            10:      v = 32'd667544;
            11:      v = 32'd333772;
            12:      v = 32'd166886;
            13:      v = 32'd83443;
            14:      v = 32'd41722;
            15:      v = 32'd20861;
            16:      v = 32'd10430;
            17:      v = 32'd5215;
            18:      v = 32'd2608;
            19:      v = 32'd1304;
            20:      v = 32'd652;
            21:      v = 32'd326;
            22:      v = 32'd163;
            23:      v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/usm_div_cell.sv -----
`default_nettype none

// One registered step of a restoring divider: shifts in the next numerator
// bit, subtracts the divisor when it fits and appends one quotient bit.
module usm_div_cell #(
    parameter int RW = 9,
    parameter int NW = 17,
    parameter int QW = 17
) (
    input  wire logic          clk,
    input  wire logic [RW-1:0] rem_in,
    input  wire logic [NW-1:0] num_in,
    input  wire logic [QW-1:0] quo_in,
    input  wire logic [RW-1:0] den_in,
    output logic      [RW-1:0] rem_out,
    output logic      [NW-1:0] num_out,
    output logic      [QW-1:0] quo_out,
    output logic      [RW-1:0] den_out
);

    logic [RW:0] trial;
    logic        fits;

    // Trial subtraction of the divisor from the shifted remainder.
    always_comb
    begin
        trial = {rem_in, num_in[NW-1]};
        fits  = (trial >= {1'b0, den_in});
    end

    always_ff @(posedge clk)
    begin
        rem_out <= fits ? RW'(trial - {1'b0, den_in}) : trial[RW-1:0];
        num_out <= num_in << 1;
        quo_out <= {quo_in[QW-2:0], fits};
        den_out <= den_in;
    end

endmodule

`default_nettype wire

// ----- rtl/usm_cordic_cell.sv -----
`default_nettype none

// One registered CORDIC rotation step with a fixed shift.
module usm_cordic_cell #(
    parameter int K = 0
) (
    input  wire logic               clk,
    input  wire logic signed [33:0] x_in,
    input  wire logic signed [33:0] y_in,
    input  wire logic signed [32:0] z_in,
    output logic      signed [33:0] x_out,
    output logic      signed [33:0] y_out,
    output logic      signed [32:0] z_out
);

    localparam logic signed [32:0] ATAN = $signed({1'b0, usm_pkg::atan_turn(K)});

    // Rotate toward zero residual angle; arithmetic shifts floor.
    always_ff @(posedge clk)
    begin
        if (!z_in[32])
        begin
            x_out <= x_in - (y_in >>> K);
            y_out <= y_in + (x_in >>> K);
            z_out <= z_in - ATAN;
        end
        else
        begin
            x_out <= x_in + (y_in >>> K);
            y_out <= y_in - (x_in >>> K);
            z_out <= z_in + ATAN;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/uv_sphere_mesh_generator_core.sv -----
`default_nettype none

// UV sphere tessellator, random access, fully pipelined.
// Input: pulse start with req_type (0 vertex, 1 triangle) and element. A
// transaction is taken at every clock edge where start is high and busy is
// low; busy stays low, so one request can enter on every cycle.
// Output: done is high for exactly one cycle with in_range, position,
// normal and corner fields of one request, in request order. The receiver
// cannot stall the block and results are not held.
// Pipeline: from the accepting edge a request passes 17 element divider
// steps, one index stage, 32 angle divider steps, the CORDIC chain, a
// quadrant stage, the multiply/round stages and a result register.
// Throughput is one request per cycle.
// Configuration: radius, ring_count, section_count written through
// cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is always high.
// Write only while no request is in flight.
// Reset: configuration returns to radius 256 and 9 x 9 bands, the pipeline
// empties, done is low. No clearing pass is needed.
module uv_sphere_mesh_generator_core #(
    parameter int CORDIC_STAGES = usm_pkg::CORDIC_STAGES_DEF,
    parameter int INDEX_BITS    = usm_pkg::INDEX_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               req_type,
    input  wire logic        [16:0] element,
    output logic                    done,
    output logic                    in_range,
    output logic signed      [16:0] pos_x,
    output logic signed      [16:0] pos_y,
    output logic signed      [16:0] pos_z,
    output logic signed      [15:0] norm_x,
    output logic signed      [15:0] norm_y,
    output logic signed      [15:0] norm_z,
    output logic             [15:0] corner_a,
    output logic             [15:0] corner_b,
    output logic             [15:0] corner_c,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic         [1:0] cfg_index,
    input  wire logic        [15:0] cfg_data
);

    localparam int DIV1_STEPS  = 17;
    localparam int PHASE_STEPS = 32;
    localparam int ST_CORNER   = DIV1_STEPS + 1;
    localparam int ST_PHASE    = ST_CORNER + PHASE_STEPS;
    localparam int PL_DEPTH    = ST_PHASE + CORDIC_STAGES + 5;
    localparam logic [17:0] IDX_MASK = 18'((64'd1 << INDEX_BITS) - 64'd1);

    typedef struct packed {
        logic        req;
        logic [16:0] elem;
        logic        rng;
        logic        pn;
        logic        ps;
        logic [15:0] ca;
        logic [15:0] cb;
        logic [15:0] cc;
        logic [1:0]  rquad;
        logic [1:0]  squad;
    } pl_t;

    // Saturating normal conversion from Q2.30 to Q1.15.
    function automatic logic signed [15:0] sat_norm(input logic signed [31:0] p);
        logic signed [32:0] t;
        t = ($signed({p[31], p}) + 33'sd16384) >>> 15;
        if (t > 33'sd32767)
            return 16'sd32767;
        else if (t < -33'sd32768)
            return -16'sd32768;
        else
            return t[15:0];
    endfunction

    // Saturating position conversion of radius times a Q2.30 value.
    function automatic logic signed [16:0] sat_pos(input logic signed [48:0] p);
        logic signed [48:0] t;
        t = (p + 49'sd536870912) >>> 30;
        if (t > 49'sd65535)
            return 17'sd65535;
        else if (t < -49'sd65535)
            return -17'sd65535;
        else
            return t[16:0];
    endfunction

    logic [15:0] radius_reg;
    logic [7:0]  ring_reg;
    logic [7:0]  sect_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= usm_pkg::RADIUS_RST;
            ring_reg   <= usm_pkg::RINGS_RST;
            sect_reg   <= usm_pkg::SECTIONS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                usm_pkg::CFG_RADIUS:   radius_reg <= cfg_data;
                usm_pkg::CFG_RINGS:    ring_reg   <= cfg_data[7:0];
                usm_pkg::CFG_SECTIONS: sect_reg   <= cfg_data[7:0];
                default:               ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    // Counts derived from the configuration, stable while requests run.
    logic [7:0]  r_cnt;
    logic [7:0]  s_cnt;
    logic [7:0]  r_m1;
    logic [8:0]  s_p1;
    logic [17:0] nverts;
    logic [17:0] ntris;
    logic [17:0] inner;
    logic [17:0] south_cap;

    always_comb
    begin
        r_cnt     = (ring_reg < 8'd3) ? 8'd3 : ring_reg;
        s_cnt     = (sect_reg < 8'd3) ? 8'd3 : sect_reg;
        r_m1      = r_cnt - 8'd1;
        s_p1      = {1'b0, s_cnt} + 9'd1;
        nverts    = 18'(r_m1) * 18'(s_p1) + 18'd2;
        ntris     = 18'(s_cnt) * 18'(r_m1) * 18'd2;
        inner     = 18'(s_cnt) * 18'(r_cnt - 8'd2) * 18'd2;
        south_cap = 18'(r_cnt - 8'd2) * 18'(s_p1) + 18'd1;
    end

    // Pipeline tags, one slot per stage.
    logic [PL_DEPTH-1:0] vld_reg;
    pl_t                 pl_reg [PL_DEPTH];
    pl_t                 pl_next [PL_DEPTH];
    logic                accept;

    assign accept = start && !busy;

    // Element divider chain.
    logic [8:0]  d1_rem [DIV1_STEPS+1];
    logic [16:0] d1_num [DIV1_STEPS+1];
    logic [16:0] d1_quo [DIV1_STEPS+1];
    logic [8:0]  d1_den [DIV1_STEPS+1];

    // Angle divider chains for ring and section.
    logic [7:0]  rg_rem [PHASE_STEPS+1];
    logic        rg_num [PHASE_STEPS+1];
    logic [31:0] rg_quo [PHASE_STEPS+1];
    logic [7:0]  rg_den [PHASE_STEPS+1];
    logic [7:0]  sc_rem [PHASE_STEPS+1];
    logic        sc_num [PHASE_STEPS+1];
    logic [31:0] sc_quo [PHASE_STEPS+1];
    logic [7:0]  sc_den [PHASE_STEPS+1];

    // Request entry: divider operands.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            d1_rem[0] <= 9'd0;
            d1_quo[0] <= 17'd0;
            d1_num[0] <= req_type ? {1'b0, element[16:1]} : element - 17'd1;
            d1_den[0] <= req_type ? {1'b0, s_cnt} : s_p1;
        end
    end

    // Corner indexes from the element divider result.
    logic [7:0]  c_a;
    logic [7:0]  c_i;
    logic [17:0] c_e;
    logic [17:0] b0;
    logic [17:0] b1;
    logic [17:0] ca_w;
    logic [17:0] cb_w;
    logic [17:0] cc_w;

    always_comb
    begin
        c_a = d1_quo[DIV1_STEPS][7:0];
        c_i = d1_rem[DIV1_STEPS][7:0];
        c_e = 18'(pl_reg[DIV1_STEPS].elem);
        b0  = 18'd1 + 18'(c_a) * 18'(s_p1) + 18'(c_i);
        b1  = b0 + 18'(s_p1);
        if (c_e < inner)
        begin
            if (!c_e[0])
            begin
                ca_w = b0 + 18'd1;
                cb_w = b0;
                cc_w = b1 + 18'd1;
            end
            else
            begin
                ca_w = b1;
                cb_w = b1 + 18'd1;
                cc_w = b0;
            end
        end
        else if (c_e < inner + 18'(s_cnt))
        begin
            ca_w = c_e - inner + 18'd1;
            cb_w = c_e - inner + 18'd2;
            cc_w = 18'd0;
        end
        else
        begin
            cb_w = south_cap + c_e - inner - 18'(s_cnt);
            ca_w = cb_w + 18'd1;
            cc_w = 18'(r_m1) * 18'(s_p1) + 18'd1;
        end
    end

    // Next tag line: entry slot with range check and pole flags, the shift,
    // and the fields that specific stages fill in.
    always_comb
    begin
        pl_next[0] = pl_reg[0];
        if (accept)
        begin
            pl_next[0].req   = req_type;
            pl_next[0].elem  = element;
            pl_next[0].rng   = req_type ? (18'(element) < ntris) : (18'(element) < nverts);
            pl_next[0].pn    = (element == 17'd0);
            pl_next[0].ps    = (18'(element) == nverts - 18'd1);
            pl_next[0].ca    = 16'd0;
            pl_next[0].cb    = 16'd0;
            pl_next[0].cc    = 16'd0;
            pl_next[0].rquad = 2'd0;
            pl_next[0].squad = 2'd0;
        end
        for (int k = 1; k < PL_DEPTH; k++)
        begin
            pl_next[k] = pl_reg[k-1];
        end
        pl_next[ST_CORNER].ca = 16'(ca_w & IDX_MASK);
        pl_next[ST_CORNER].cb = 16'(cb_w & IDX_MASK);
        pl_next[ST_CORNER].cc = 16'(cc_w & IDX_MASK);
        pl_next[ST_PHASE+1].rquad = {1'b0, rg_quo[PHASE_STEPS][31]};
        pl_next[ST_PHASE+1].squad = sc_quo[PHASE_STEPS][31:30];
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < PL_DEPTH; k++)
        begin
            pl_reg[k] <= pl_next[k];
        end
        // Angle dividend setup: ring number and section number.
        rg_rem[0] <= c_a + 8'd1;
        rg_num[0] <= 1'b0;
        rg_quo[0] <= 32'd0;
        rg_den[0] <= r_cnt;
        sc_rem[0] <= ({1'b0, c_i} == {1'b0, s_cnt}) ? 8'd0 : c_i;
        sc_num[0] <= 1'b0;
        sc_quo[0] <= 32'd0;
        sc_den[0] <= s_cnt;
    end

    // Valid bits of the tag line.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[PL_DEPTH-2:0], accept};
    end

    // Element divider: quotient is ring or quad row, remainder the section.
    for (genvar g = 0; g < DIV1_STEPS; g++)
    begin : g_div1
        usm_div_cell #(.RW(9), .NW(17), .QW(17)) u_cell (
            .clk     (clk),
            .rem_in  (d1_rem[g]),
            .num_in  (d1_num[g]),
            .quo_in  (d1_quo[g]),
            .den_in  (d1_den[g]),
            .rem_out (d1_rem[g+1]),
            .num_out (d1_num[g+1]),
            .quo_out (d1_quo[g+1]),
            .den_out (d1_den[g+1])
        );
    end

    // Angle dividers: turn fractions of the ring and section angles.
    for (genvar g = 0; g < PHASE_STEPS; g++)
    begin : g_phase
        usm_div_cell #(.RW(8), .NW(1), .QW(32)) u_ring (
            .clk     (clk),
            .rem_in  (rg_rem[g]),
            .num_in  (rg_num[g]),
            .quo_in  (rg_quo[g]),
            .den_in  (rg_den[g]),
            .rem_out (rg_rem[g+1]),
            .num_out (rg_num[g+1]),
            .quo_out (rg_quo[g+1]),
            .den_out (rg_den[g+1])
        );
        usm_div_cell #(.RW(8), .NW(1), .QW(32)) u_sect (
            .clk     (clk),
            .rem_in  (sc_rem[g]),
            .num_in  (sc_num[g]),
            .quo_in  (sc_quo[g]),
            .den_in  (sc_den[g]),
            .rem_out (sc_rem[g+1]),
            .num_out (sc_num[g+1]),
            .quo_out (sc_quo[g+1]),
            .den_out (sc_den[g+1])
        );
    end

    // CORDIC chains; the ring phase is half the divider quotient.
    logic signed [33:0] rx [CORDIC_STAGES+1];
    logic signed [33:0] ry [CORDIC_STAGES+1];
    logic signed [32:0] rz [CORDIC_STAGES+1];
    logic signed [33:0] sx [CORDIC_STAGES+1];
    logic signed [33:0] sy [CORDIC_STAGES+1];
    logic signed [32:0] sz [CORDIC_STAGES+1];

    assign rx[0] = usm_pkg::CORDIC_GAIN;
    assign ry[0] = 34'sd0;
    assign rz[0] = $signed({3'b000, rg_quo[PHASE_STEPS][30:1]});
    assign sx[0] = usm_pkg::CORDIC_GAIN;
    assign sy[0] = 34'sd0;
    assign sz[0] = $signed({3'b000, sc_quo[PHASE_STEPS][29:0]});

    for (genvar g = 0; g < CORDIC_STAGES; g++)
    begin : g_cordic
        usm_cordic_cell #(.K(g)) u_ring (
            .clk   (clk),
            .x_in  (rx[g]),
            .y_in  (ry[g]),
            .z_in  (rz[g]),
            .x_out (rx[g+1]),
            .y_out (ry[g+1]),
            .z_out (rz[g+1])
        );
        usm_cordic_cell #(.K(g)) u_sect (
            .clk   (clk),
            .x_in  (sx[g]),
            .y_in  (sy[g]),
            .z_in  (sz[g]),
            .x_out (sx[g+1]),
            .y_out (sy[g+1]),
            .z_out (sz[g+1])
        );
    end

    // Quadrant fold into cosine and sine.
    logic signed [31:0] q_rc_reg;
    logic signed [31:0] q_rs_reg;
    logic signed [31:0] q_sc_reg;
    logic signed [31:0] q_ss_reg;
    logic signed [33:0] fx_r;
    logic signed [33:0] fy_r;
    logic signed [33:0] fx_s;
    logic signed [33:0] fy_s;
    pl_t                pq;

    always_comb
    begin
        pq   = pl_reg[ST_PHASE+CORDIC_STAGES];
        fx_r = rx[CORDIC_STAGES];
        fy_r = ry[CORDIC_STAGES];
        fx_s = sx[CORDIC_STAGES];
        fy_s = sy[CORDIC_STAGES];
    end

    always_ff @(posedge clk)
    begin
        case (pq.rquad)
            2'd0:
            begin
                q_rc_reg <= fx_r[31:0];
                q_rs_reg <= fy_r[31:0];
            end
            2'd1:
            begin
                q_rc_reg <= 32'(-fy_r);
                q_rs_reg <= fx_r[31:0];
            end
            2'd2:
            begin
                q_rc_reg <= 32'(-fx_r);
                q_rs_reg <= 32'(-fy_r);
            end
            default:
            begin
                q_rc_reg <= fy_r[31:0];
                q_rs_reg <= 32'(-fx_r);
            end
        endcase
        case (pq.squad)
            2'd0:
            begin
                q_sc_reg <= fx_s[31:0];
                q_ss_reg <= fy_s[31:0];
            end
            2'd1:
            begin
                q_sc_reg <= 32'(-fy_s);
                q_ss_reg <= fx_s[31:0];
            end
            2'd2:
            begin
                q_sc_reg <= 32'(-fx_s);
                q_ss_reg <= 32'(-fy_s);
            end
            default:
            begin
                q_sc_reg <= fy_s[31:0];
                q_ss_reg <= 32'(-fx_s);
            end
        endcase
    end

    // Ring-weighted products, then rounding and normals.
    logic signed [63:0] m1_px_reg;
    logic signed [63:0] m1_py_reg;
    logic signed [31:0] m1_rc_reg;
    logic signed [31:0] m2_px_reg;
    logic signed [31:0] m2_py_reg;
    logic signed [31:0] m2_rc_reg;
    logic signed [15:0] m2_nx_reg;
    logic signed [15:0] m2_ny_reg;
    logic signed [15:0] m2_nz_reg;
    logic signed [48:0] m3_xp_reg;
    logic signed [48:0] m3_yp_reg;
    logic signed [48:0] m3_zp_reg;
    logic signed [15:0] m3_nx_reg;
    logic signed [15:0] m3_ny_reg;
    logic signed [15:0] m3_nz_reg;
    logic signed [63:0] rnd_x;
    logic signed [63:0] rnd_y;
    logic signed [16:0] rad_s;

    always_comb
    begin
        rnd_x = (m1_px_reg + 64'sd536870912) >>> 30;
        rnd_y = (m1_py_reg + 64'sd536870912) >>> 30;
        rad_s = $signed({1'b0, radius_reg});
    end

    always_ff @(posedge clk)
    begin
        m1_px_reg <= q_sc_reg * q_rs_reg;
        m1_py_reg <= q_ss_reg * q_rs_reg;
        m1_rc_reg <= q_rc_reg;
        m2_px_reg <= rnd_x[31:0];
        m2_py_reg <= rnd_y[31:0];
        m2_rc_reg <= m1_rc_reg;
        m2_nx_reg <= sat_norm(rnd_x[31:0]);
        m2_ny_reg <= sat_norm(rnd_y[31:0]);
        m2_nz_reg <= sat_norm(m1_rc_reg);
        m3_xp_reg <= rad_s * m2_px_reg;
        m3_yp_reg <= rad_s * m2_py_reg;
        m3_zp_reg <= rad_s * m2_rc_reg;
        m3_nx_reg <= m2_nx_reg;
        m3_ny_reg <= m2_ny_reg;
        m3_nz_reg <= m2_nz_reg;
    end

    // Result register: select vertex, pole, triangle or out-of-range result.
    logic               done_reg;
    logic               rng_reg;
    logic signed [16:0] px_reg;
    logic signed [16:0] py_reg;
    logic signed [16:0] pz_reg;
    logic signed [15:0] nx_reg;
    logic signed [15:0] ny_reg;
    logic signed [15:0] nz_reg;
    logic [15:0]        ca_reg;
    logic [15:0]        cb_reg;
    logic [15:0]        cc_reg;
    logic signed [16:0] px_next;
    logic signed [16:0] py_next;
    logic signed [16:0] pz_next;
    logic signed [15:0] nx_next;
    logic signed [15:0] ny_next;
    logic signed [15:0] nz_next;
    logic [15:0]        ca_next;
    logic [15:0]        cb_next;
    logic [15:0]        cc_next;
    pl_t                po;

    assign po = pl_reg[PL_DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vld_reg[PL_DEPTH-1];
    end

    always_comb
    begin
        px_next = 17'sd0;
        py_next = 17'sd0;
        pz_next = 17'sd0;
        nx_next = 16'sd0;
        ny_next = 16'sd0;
        nz_next = 16'sd0;
        ca_next = 16'd0;
        cb_next = 16'd0;
        cc_next = 16'd0;
        if (po.rng)
        begin
            if (po.req)
            begin
                ca_next = po.ca;
                cb_next = po.cb;
                cc_next = po.cc;
            end
            else if (po.pn)
            begin
                pz_next = rad_s;
                nz_next = 16'sd32767;
            end
            else if (po.ps)
            begin
                pz_next = -rad_s;
                nz_next = 16'sd32767;
            end
            else
            begin
                px_next = sat_pos(m3_xp_reg);
                py_next = sat_pos(m3_yp_reg);
                pz_next = sat_pos(m3_zp_reg);
                nx_next = m3_nx_reg;
                ny_next = m3_ny_reg;
                nz_next = m3_nz_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rng_reg <= po.rng;
        px_reg  <= px_next;
        py_reg  <= py_next;
        pz_reg  <= pz_next;
        nx_reg  <= nx_next;
        ny_reg  <= ny_next;
        nz_reg  <= nz_next;
        ca_reg  <= ca_next;
        cb_reg  <= cb_next;
        cc_reg  <= cc_next;
    end

    assign done     = done_reg;
    assign in_range = rng_reg;
    assign pos_x    = px_reg;
    assign pos_y    = py_reg;
    assign pos_z    = pz_reg;
    assign norm_x   = nx_reg;
    assign norm_y   = ny_reg;
    assign norm_z   = nz_reg;
    assign corner_a = ca_reg;
    assign corner_b = cb_reg;
    assign corner_c = cc_reg;

`ifndef SYNTHESIS
    // Every accepted transaction produces its result, checked against the pipeline depth.
    ap_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##PL_DEPTH done)
        else $error("result missing after pipeline latency");

    // No result appears without a request having entered the pipeline.
    ap_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(vld_reg[PL_DEPTH-1]))
        else $error("result without request");

    // An out-of-range result carries zeros in position, norm_z, corner_a and corner_c.
    ap_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !in_range) |-> (pos_x == 17'sd0 && pos_y == 17'sd0 &&
            pos_z == 17'sd0 && norm_z == 16'sd0 && corner_a == 16'd0 &&
            corner_c == 16'd0))
        else $error("out-of-range result not cleared");

    // A result is either geometry or corners, never both.
    ap_kind: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((corner_a == 16'd0 && corner_b == 16'd0 && corner_c == 16'd0) ||
            (pos_x == 17'sd0 && pos_y == 17'sd0 && pos_z == 17'sd0 &&
             norm_x == 16'sd0 && norm_y == 16'sd0 && norm_z == 16'sd0)))
        else $error("vertex and triangle fields mixed");
`endif

endmodule

`default_nettype wire
